// ===== design/fbpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg - shared definitions for the fixed block pool allocator
// Field widths, register indexes, request kinds, status codes and defaults.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned SIZE_W      = 16;
    localparam int unsigned CFG_CNT_W   = 11;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam int unsigned MAX_SLOTS_DEF    = 1024;
    localparam int unsigned HEADER_BYTES_DEF = 16;
    localparam int unsigned IDX_W_DEF        = $clog2(MAX_SLOTS_DEF);

    localparam logic [ADDR_W-1:0]    BASE_ADDR_RST  = '0;
    localparam logic [SIZE_W-1:0]    SLOT_SIZE_RST  = 16'd64;
    localparam logic [CFG_CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDR  = 2'd0,
        REG_SLOT_SIZE  = 2'd1,
        REG_SLOT_COUNT = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_BAD_FREE = 2'd2,
        STAT_RSVD     = 2'd3
    } status_t;

    // divider result, valid for one cycle
    typedef struct packed {
        logic              done;
        logic              exact;
        logic [ADDR_W-1:0] quot;
    } div_res_t;

endpackage

// ===== design/fbpa_serial_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_serial_mul - bit-serial slot offset multiplier
// Shift-add product of slot index and slot size, one index bit per cycle.
// Product is taken modulo 2^32.
// ----------------------------------------------------------------------------
module fbpa_serial_mul #(
    parameter int unsigned IDX_W = fbpa_pkg::IDX_W_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [IDX_W-1:0]            idx,
    input  logic [fbpa_pkg::SIZE_W-1:0] size,
    output logic                        done,
    output logic [fbpa_pkg::ADDR_W-1:0] prod
);
    import fbpa_pkg::*;

    localparam int unsigned CNT_W = $clog2(IDX_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  mplier_reg;
    logic [ADDR_W-1:0] mcand_reg;
    logic [ADDR_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(IDX_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mplier_reg <= idx;
            mcand_reg  <= ADDR_W'(size);
            acc_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[ADDR_W-2:0], 1'b0};
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

    busy_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("multiplier restarted while busy");

    done_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_W'(1) && !start) |=> (done_reg && !busy_reg))
        else $error("multiplier did not finish after last step");

    done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held for more than one cycle");

endmodule

// ===== design/fbpa_serial_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_serial_div - restoring divider for address to index conversion
// One quotient bit per cycle; reports quotient and whether remainder is zero.
// ----------------------------------------------------------------------------
module fbpa_serial_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
    output fbpa_pkg::div_res_t          res
);
    import fbpa_pkg::*;

    localparam int unsigned CNT_W = $clog2(ADDR_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ADDR_W-1:0] quot_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [SIZE_W-1:0] dvsr_reg;
    logic [SIZE_W:0]   trial;
    logic              qbit;

    // bring down the next dividend bit and try a subtract
    assign trial = {rem_reg, quot_reg[ADDR_W-1]};
    assign qbit  = (trial >= {1'b0, dvsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ADDR_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dvsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[ADDR_W-2:0], qbit};
            if (qbit)
                rem_reg <= SIZE_W'(trial - {1'b0, dvsr_reg});
            else
                rem_reg <= trial[SIZE_W-1:0];
        end
    end

    assign res.done  = done_reg;
    assign res.exact = (rem_reg == '0);
    assign res.quot  = quot_reg;

    busy_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvsr_reg))
        else $error("divider remainder not below divisor");

    done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");

endmodule

// ===== design/fixed_block_pool_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top - fixed-size block pool allocator
// LIFO free list of equal-size slots with lazy fresh-slot region.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                        | beat contents
//  ---------+-----+--------------------------------+------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata s_tuser | block_addr; kind
//  m_       | out | m_tvalid m_tready m_tdata m_tuser | addr; status
//  cfg_     | in  | cfg_we cfg_index cfg_data       | 0 base_addr, 1 slot_size,
//           |     |                                |   2 slot_count
//
//  Alloc: waits in the alloc state on the bit-serial offset multiplier.
//  Free: waits on the 32-step restoring divider, unless rejected before it.
//  Clear, empty alloc and unknown kind go straight to the done state.
//  One request at a time; the next beat is taken once the result sits in the
//  output register, so a stalled result holds up at most one request.
//  Reset clears the list head and fresh count and loads the config defaults;
//  link RAM needs no clear.
module fixed_block_pool_allocator_top #(
    parameter int unsigned MAX_SLOTS    = fbpa_pkg::MAX_SLOTS_DEF,
    parameter int unsigned HEADER_BYTES = fbpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fbpa_pkg::ADDR_W-1:0]     s_tdata,   // [31:0] block_addr
    input  logic [fbpa_pkg::KIND_W-1:0]     s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fbpa_pkg::ADDR_W-1:0]     m_tdata,   // [31:0] addr
    output logic [fbpa_pkg::STATUS_W-1:0]   m_tuser,   // [1:0] status
    input  logic                            cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fbpa_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_SLOTS);
    localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
    localparam logic [ADDR_W-1:0] MAX_SLOTS_A = ADDR_W'(MAX_SLOTS);
    localparam logic [ADDR_W-1:0] HEADER_A    = ADDR_W'(HEADER_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_ALLOC    = 5'b00010,
        ST_FREE_SUB = 5'b00100,
        ST_FREE_DIV = 5'b01000,
        ST_DONE     = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  base_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [CFG_CNT_W-1:0] count_reg;

    logic [IDX_W-1:0]   head_reg, head_next;
    logic               nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]   fresh_reg, fresh_next;
    logic               from_list_reg, from_list_next;
    logic [ADDR_W-1:0]  blk_reg;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    status_t            res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [ADDR_W-1:0]  m_addr_reg;
    status_t            m_status_reg;

    logic [IDX_W:0]     link_mem [MAX_SLOTS];
    logic [IDX_W:0]     link_rd_reg;

    logic               accept;
    req_kind_t          kind;
    logic               fresh_avail;
    logic               mul_start, mul_done;
    logic [IDX_W-1:0]   mul_idx;
    logic [ADDR_W-1:0]  mul_prod;
    logic               div_start;
    div_res_t           div_res;
    logic [ADDR_W+1:0]  offs;
    logic               free_ok;
    logic               out_free;

    assign kind     = req_kind_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign fresh_avail = (ADDR_W'(fresh_reg) < ADDR_W'(count_reg)) &&
                         (ADDR_W'(fresh_reg) < MAX_SLOTS_A);

    assign mul_start = accept && (kind == KIND_ALLOC) && (nonempty_reg || fresh_avail);
    assign mul_idx   = nonempty_reg ? head_reg : fresh_reg[IDX_W-1:0];

    // distance of the user address from slot 0's payload; negative means bad
    assign offs      = {2'b00, blk_reg} - {2'b00, base_reg} - {2'b00, HEADER_A};
    assign div_start = (state_reg == ST_FREE_SUB) && !offs[ADDR_W+1] && (size_reg != '0);

    assign free_ok = div_res.exact &&
                     (div_res.quot < ADDR_W'(count_reg)) &&
                     (div_res.quot < MAX_SLOTS_A) &&
                     (div_res.quot < ADDR_W'(fresh_reg));

    fbpa_serial_mul #(
        .IDX_W (IDX_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .idx   (mul_idx),
        .size  (size_reg),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    fbpa_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (offs[ADDR_W-1:0]),
        .divisor  (size_reg),
        .res      (div_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        nonempty_next   = nonempty_reg;
        fresh_next      = fresh_reg;
        from_list_next  = from_list_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_addr_next   = '0;
                    res_status_next = STAT_OK;
                    unique case (kind)
                        KIND_ALLOC:
                        begin
                            from_list_next = nonempty_reg;
                            if (nonempty_reg || fresh_avail)
                                state_next = ST_ALLOC;
                            else
                            begin
                                res_status_next = STAT_EMPTY;
                                state_next      = ST_DONE;
                            end
                        end
                        KIND_FREE:
                            state_next = ST_FREE_SUB;
                        KIND_CLEAR:
                        begin
                            nonempty_next = 1'b0;
                            head_next     = '0;
                            fresh_next    = '0;
                            state_next    = ST_DONE;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_ALLOC:
            begin
                if (mul_done)
                begin
                    res_addr_next = base_reg + mul_prod + HEADER_A;
                    if (from_list_reg)
                    begin
                        head_next     = link_rd_reg[IDX_W-1:0];
                        nonempty_next = link_rd_reg[IDX_W];
                    end
                    else
                        fresh_next = fresh_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end
            ST_FREE_SUB:
            begin
                if (div_start)
                    state_next = ST_FREE_DIV;
                else
                begin
                    res_status_next = STAT_BAD_FREE;
                    state_next      = ST_DONE;
                end
            end
            ST_FREE_DIV:
            begin
                if (div_res.done)
                begin
                    if (free_ok)
                    begin
                        head_next     = div_res.quot[IDX_W-1:0];
                        nonempty_next = 1'b1;
                    end
                    else
                        res_status_next = STAT_BAD_FREE;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            nonempty_reg  <= 1'b0;
            fresh_reg     <= '0;
            from_list_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            base_reg      <= BASE_ADDR_RST;
            size_reg      <= SLOT_SIZE_RST;
            count_reg     <= SLOT_COUNT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            nonempty_reg  <= nonempty_next;
            fresh_reg     <= fresh_next;
            from_list_reg <= from_list_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_BASE_ADDR:  base_reg  <= cfg_data[ADDR_W-1:0];
                    REG_SLOT_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                    REG_SLOT_COUNT: count_reg <= cfg_data[CFG_CNT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (accept)
            blk_reg <= s_tdata;
        if (state_reg == ST_DONE && out_free)
        begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
    end

    // link RAM: read the head's link on every accepted request, push on a good free
    always_ff @(posedge clk)
    begin
        if (accept)
            link_rd_reg <= link_mem[head_reg];
        if (state_reg == ST_FREE_DIV && div_res.done && free_ok)
            link_mem[div_res.quot[IDX_W-1:0]] <= {nonempty_reg, head_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    mul_done_in_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_ALLOC))
        else $error("multiplier finished outside alloc");

    div_done_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_FREE_DIV))
        else $error("divider finished outside free");

    fresh_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ADDR_W'(fresh_reg) <= MAX_SLOTS_A)
        else $error("fresh count beyond pool size");

    result_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("result not moved to output register");

endmodule
